// ----- design/rrq_pkg.sv -----
// Shared types for the round-robin ready queue.
// Action and status codes, sequencer states and the result record.
// No dependencies.
`default_nettype none

package rrq_pkg;

	// request action codes
	typedef enum logic [1:0] {
		ACT_SCHEDULE  = 2'd0,
		ACT_READY     = 2'd1,
		ACT_NOT_READY = 2'd2
	} action_e_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_EMPTY     = 2'd3
	} status_e_t;

	// sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_SCHED_RD,
		S_SEARCH,
		S_SHIFT,
		S_FINISH
	} state_e_t;

	// per-request result flags
	typedef struct packed {
		logic      switched;
		status_e_t status;
	} rrq_res_t;

endpackage

`default_nettype wire

// ----- design/rrq_mem.sv -----
// Queue entry storage: one write port, one read port with registered data.
// No package dependencies.
`default_nettype none

module rrq_mem #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write one entry, read one entry per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ----- design/rrq_ctrl.sv -----
// Sequencer for the ready queue: circular-buffer pointers, running thread,
// and the shared compare/copy step used for search and gap closing.
// Depends on rrq_pkg; drives the ports of rrq_mem.
`default_nettype none

module rrq_ctrl import rrq_pkg::*; #(
	parameter int QUEUE_DEPTH = 16,
	parameter int THREAD_ID_BITS = 8,
	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
	localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_wr_en,
	input  wire logic [THREAD_ID_BITS-1:0] cfg_wr_data,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [1:0]                action,
	input  wire logic [THREAD_ID_BITS-1:0] thread_id,
	output logic                           res_valid,
	input  wire logic                      res_take,
	output rrq_res_t                       res,
	output logic      [THREAD_ID_BITS-1:0] cur_thread,
	output logic      [CW-1:0]             count,
	output logic                           mem_we,
	output logic      [AW-1:0]             mem_waddr,
	output logic      [THREAD_ID_BITS-1:0] mem_wdata,
	output logic      [AW-1:0]             mem_raddr,
	input  wire logic [THREAD_ID_BITS-1:0] mem_rdata
);

	localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
	localparam logic [CW-1:0] ONE_C = CW'(1);
	localparam logic [CW-1:0] TWO_C = CW'(2);

	state_e_t                  state_q, state_d;
	logic [AW-1:0]             head_q, head_d;
	logic [CW-1:0]             count_q, count_d;
	logic [THREAD_ID_BITS-1:0] cur_q, cur_d;
	logic [CW-1:0]             off_q, off_d;
	logic [THREAD_ID_BITS-1:0] tid_q, tid_d;
	rrq_res_t                  res_q, res_d;
	logic                      hit;
	logic                      last;

	// map a queue offset from the head to a physical entry address
	function automatic logic [AW-1:0] wrap_addr(input logic [AW-1:0] base,
			input logic [CW-1:0] off);
		logic [CW:0] sum;
		sum = {{(CW + 1 - AW){1'b0}}, base} + {1'b0, off};
		if (sum >= (CW + 1)'(QUEUE_DEPTH)) begin
			sum = sum - (CW + 1)'(QUEUE_DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	// shared compare unit: entry read last cycle against requested ID
	assign hit  = (mem_rdata == tid_q);
	assign last = ((off_q + ONE_C) == count_q);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			count_q <= '0;
			cur_q   <= '0;
			off_q   <= '0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			count_q <= count_d;
			cur_q   <= cur_d;
			off_q   <= off_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		tid_q <= tid_d;
		res_q <= res_d;
	end

	// next state, memory access and result flags
	always_comb begin
		state_d   = state_q;
		head_d    = head_q;
		count_d   = count_q;
		cur_d     = cur_q;
		off_d     = off_q;
		tid_d     = tid_q;
		res_d     = res_q;
		mem_we    = 1'b0;
		mem_waddr = wrap_addr(head_q, count_q);
		mem_wdata = tid_q;
		mem_raddr = head_q;
		in_ready  = 1'b0;
		res_valid = 1'b0;

		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					tid_d = thread_id;
					off_d = '0;
					res_d.switched = 1'b0;
					res_d.status = ST_OK;
					state_d = S_FINISH;
					case (action)
						ACT_SCHEDULE: begin
							// read the head now, rotate next cycle
							if (count_q == '0) begin
								res_d.status = ST_EMPTY;
							end else begin
								state_d = S_SCHED_RD;
							end
						end
						ACT_READY: begin
							// append at the tail
							if (count_q == DEPTH_C) begin
								res_d.status = ST_FULL;
							end else begin
								mem_we    = 1'b1;
								mem_wdata = thread_id;
								count_d   = count_q + ONE_C;
							end
						end
						ACT_NOT_READY: begin
							// head read is issued; start the search
							if (count_q == '0) begin
								res_d.status = ST_NOT_FOUND;
							end else begin
								state_d = S_SEARCH;
							end
						end
						default: begin
							res_d.status = ST_OK;
						end
					endcase
				end
			end

			S_SCHED_RD: begin
				// old running thread to the tail, head becomes running
				mem_we         = 1'b1;
				mem_wdata      = cur_q;
				cur_d          = mem_rdata;
				head_d         = wrap_addr(head_q, ONE_C);
				res_d.switched = 1'b1;
				res_d.status   = ST_OK;
				state_d        = S_FINISH;
			end

			S_SEARCH: begin
				// compare one entry per cycle, prefetch the next
				mem_raddr = wrap_addr(head_q, off_q + ONE_C);
				if (hit) begin
					if (last) begin
						count_d = count_q - ONE_C;
						res_d.status = ST_OK;
						state_d = S_FINISH;
					end else begin
						state_d = S_SHIFT;
					end
				end else if (last) begin
					res_d.status = ST_NOT_FOUND;
					state_d = S_FINISH;
				end else begin
					off_d = off_q + ONE_C;
				end
			end

			S_SHIFT: begin
				// close the gap: move the following entry down by one
				mem_we    = 1'b1;
				mem_waddr = wrap_addr(head_q, off_q);
				mem_wdata = mem_rdata;
				mem_raddr = wrap_addr(head_q, off_q + TWO_C);
				off_d     = off_q + ONE_C;
				if ((off_q + TWO_C) == count_q) begin
					count_d = count_q - ONE_C;
					res_d.status = ST_OK;
					state_d = S_FINISH;
				end
			end

			S_FINISH: begin
				// hold until the output register takes the result
				res_valid = 1'b1;
				if (res_take) begin
					state_d = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase

		// load the running thread from the register write
		if (cfg_wr_en) begin
			cur_d = cfg_wr_data;
		end
	end

	assign res        = res_q;
	assign cur_thread = cur_q;
	assign count      = count_q;

	// queue never holds more than its depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("queue count above depth");

	// count moves by at most one per cycle
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |->
		((count_q == $past(count_q) + ONE_C) || (count_q + ONE_C == $past(count_q))))
		else $error("queue count jumped");

	// rotation keeps the count
	a_sched_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCHED_RD) |=> (count_q == $past(count_q)))
		else $error("schedule changed queue count");

	// a ready request on a full queue reports full
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && action == ACT_READY && count_q == DEPTH_C) |=>
		(state_q == S_FINISH && res_q.status == ST_FULL))
		else $error("full queue not reported");

	// search and shift offsets stay inside the occupied entries
	a_off_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SEARCH || state_q == S_SHIFT) |-> (off_q < count_q))
		else $error("offset beyond queue count");

endmodule

`default_nettype wire

// ----- design/round_robin_ready_queue.sv -----
// Round-robin ready queue of thread IDs with a running-thread register. A request is
// accepted only while the sequencer is idle. Its result goes to the output register
// from S_FINISH; a schedule first passes S_SCHED_RD (not on an empty queue), a ready
// request or the unused action code goes straight to S_FINISH, and a not-ready request
// on a non-empty queue passes S_SEARCH and then S_SHIFT while entries follow the match,
// since the single-read-port entry memory is scanned one entry per cycle to find the
// match and then read again one entry per cycle to close the gap. The next request is
// taken the cycle after the result is handed over. While the output register still
// holds an undrained result, the sequencer keeps its result and the input waits.
// Depends on rrq_pkg, rrq_ctrl and rrq_mem.
`default_nettype none

module round_robin_ready_queue import rrq_pkg::*; #(
	parameter int QUEUE_DEPTH = 16,
	parameter int THREAD_ID_BITS = 8,
	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
	localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_wr_en,
	input  wire logic [THREAD_ID_BITS-1:0] cfg_wr_data,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [1:0]                action,
	input  wire logic [THREAD_ID_BITS-1:0] thread_id,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic      [THREAD_ID_BITS-1:0] running_thread,
	output logic                           switched,
	output logic      [1:0]                status,
	output logic      [CW-1:0]             queue_count
);

	logic                      res_valid;
	logic                      res_take;
	rrq_res_t                  res;
	logic [THREAD_ID_BITS-1:0] cur_thread;
	logic [CW-1:0]             count;
	logic                      mem_we;
	logic [AW-1:0]             mem_waddr;
	logic [THREAD_ID_BITS-1:0] mem_wdata;
	logic [AW-1:0]             mem_raddr;
	logic [THREAD_ID_BITS-1:0] mem_rdata;

	logic                      out_valid_q;
	logic [THREAD_ID_BITS-1:0] running_thread_q;
	logic                      switched_q;
	logic [1:0]                status_q;
	logic [CW-1:0]             queue_count_q;

	rrq_ctrl #(
		.QUEUE_DEPTH   (QUEUE_DEPTH),
		.THREAD_ID_BITS(THREAD_ID_BITS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.action     (action),
		.thread_id  (thread_id),
		.res_valid  (res_valid),
		.res_take   (res_take),
		.res        (res),
		.cur_thread (cur_thread),
		.count      (count),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata)
	);

	rrq_mem #(
		.DEPTH(QUEUE_DEPTH),
		.WIDTH(THREAD_ID_BITS)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// take a result when the output register is empty or being drained
	assign res_take = !out_valid_q || out_ready;

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (res_valid && res_take) begin
			running_thread_q <= cur_thread;
			switched_q       <= res.switched;
			status_q         <= res.status;
			queue_count_q    <= count;
		end
	end

	assign out_valid      = out_valid_q;
	assign running_thread = running_thread_q;
	assign switched       = switched_q;
	assign status         = status_q;
	assign queue_count    = queue_count_q;

endmodule

`default_nettype wire

// ----- sim/round_robin_ready_queue_tb.sv -----
// Self-checking testbench for round_robin_ready_queue: directed and random requests,
// with results checked against a behavioral model of the ready queue.
// Depends on rrq_pkg and the round_robin_ready_queue RTL.

module round_robin_ready_queue_tb import rrq_pkg::*;;

	localparam int QUEUE_DEPTH = 16;
	localparam int ID_BITS = 8;
	localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int IDLE_LIMIT = 1000;

	typedef struct {
		logic [ID_BITS-1:0]  running;
		logic                switched;
		status_e_t           status;
		logic [CNT_BITS-1:0] count;
	} outcome_t;

	typedef enum int {RX_STEADY, RX_RANDOM, RX_PERIODIC} rx_mode_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_wr_en;
	logic [ID_BITS-1:0]  cfg_wr_data;
	logic                in_valid;
	logic                in_ready;
	logic [1:0]          action;
	logic [ID_BITS-1:0]  thread_id;
	logic                out_valid;
	logic                out_ready;
	logic [ID_BITS-1:0]  running_thread;
	logic                switched;
	logic [1:0]          status;
	logic [CNT_BITS-1:0] queue_count;

	// behavioral copy of the scheduler state
	logic [ID_BITS-1:0] waiting_ids[$];
	logic [ID_BITS-1:0] running_id;
	outcome_t           pending_outcomes[$];

	int error_count;
	int idle_cycles;
	int burst_left;
	int rx_left;
	int rx_step;
	rx_mode_t rx_mode;

	round_robin_ready_queue #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.THREAD_ID_BITS(ID_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.thread_id(thread_id),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.running_thread(running_thread),
		.switched(switched),
		.status(status),
		.queue_count(queue_count)
	);

	always #6 clk = ~clk;

	// apply one accepted request to the model and queue its outcome
	function automatic void predict_request(logic [1:0] act, logic [ID_BITS-1:0] tid);
		outcome_t o;
		o.switched = 1'b0;
		o.status = ST_OK;
		case (act)
			ACT_SCHEDULE: begin
				if (waiting_ids.size() == 0) begin
					o.status = ST_EMPTY;
				end else begin
					waiting_ids.push_back(running_id);
					running_id = waiting_ids.pop_front();
					o.switched = 1'b1;
				end
			end
			ACT_READY: begin
				if (waiting_ids.size() >= QUEUE_DEPTH)
					o.status = ST_FULL;
				else
					waiting_ids.push_back(tid);
			end
			ACT_NOT_READY: begin
				o.status = ST_NOT_FOUND;
				for (int k = 0; k < waiting_ids.size(); k++) begin
					if (waiting_ids[k] == tid) begin
						waiting_ids.delete(k);
						o.status = ST_OK;
						break;
					end
				end
			end
			default: begin
			end
		endcase
		o.running = running_id;
		o.count = CNT_BITS'(waiting_ids.size());
		pending_outcomes.push_back(o);
	endfunction

	// send one request; the sender runs in bursts with random gaps
	task automatic send_request(logic [1:0] act, logic [ID_BITS-1:0] tid);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		action <= act;
		thread_id <= tid;
		do @(posedge clk); while (!in_ready);
		predict_request(act, tid);
	endtask

	// drop valid and wait until every result has come back
	task automatic drain_requests();
		@(negedge clk);
		in_valid <= 1'b0;
		burst_left = 0;
		while (pending_outcomes.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// write the start-thread register while the block is idle
	task automatic load_start_thread(logic [ID_BITS-1:0] tid);
		drain_requests();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= tid;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		running_id = tid;
	endtask

	task automatic report_mismatch(string field, logic [ID_BITS-1:0] want,
			logic [ID_BITS-1:0] got);
		$display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
		error_count++;
	endtask

	// a run of random requests with the given mix of actions (percent)
	task automatic random_phase(int n, int ready_pct, int remove_pct);
		int r;
		logic [1:0] act;
		logic [ID_BITS-1:0] tid;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			tid = ID_BITS'($urandom);
			if (r < ready_pct) begin
				act = ACT_READY;
				// reuse a small pool now and then to build duplicates
				if ($urandom_range(0, 1) == 0)
					tid = {3'($urandom_range(0, 7)), 5'b10110} ^ {ID_BITS{r[0]}};
			end else if (r < ready_pct + remove_pct) begin
				act = ACT_NOT_READY;
				if (waiting_ids.size() > 0 && $urandom_range(0, 3) != 0)
					tid = waiting_ids[$urandom_range(0, waiting_ids.size() - 1)];
			end else if (r < 98) begin
				act = ACT_SCHEDULE;
			end else begin
				act = ACT_UNUSED;
			end
			send_request(act, tid);
		end
	endtask

	task automatic test_empty_queue();
		send_request(ACT_SCHEDULE, 8'h00);
		send_request(ACT_NOT_READY, 8'h55);
		send_request(ACT_UNUSED, 8'hAA);
	endtask

	task automatic test_rotation_and_removal();
		load_start_thread(8'hFF);
		send_request(ACT_READY, 8'hFF);
		send_request(ACT_READY, 8'h00);
		send_request(ACT_READY, 8'hA5);
		send_request(ACT_READY, 8'h00);
		send_request(ACT_READY, 8'h5A);
		// head equals the running thread: still rotates
		send_request(ACT_SCHEDULE, 8'h00);
		// duplicate: only the one nearest the head goes
		send_request(ACT_NOT_READY, 8'h00);
		send_request(ACT_NOT_READY, 8'h77);
		send_request(ACT_NOT_READY, 8'hFF);
		send_request(ACT_SCHEDULE, 8'hFF);
	endtask

	task automatic test_queue_full();
		load_start_thread(8'h00);
		while (waiting_ids.size() < QUEUE_DEPTH)
			send_request(ACT_READY, ID_BITS'($urandom));
		send_request(ACT_READY, 8'hC3);
		send_request(ACT_SCHEDULE, 8'h3C);
	endtask

	task automatic test_random_mix();
		random_phase(300, 70, 10);
		load_start_thread(ID_BITS'($urandom));
		random_phase(300, 35, 30);
		load_start_thread(8'hFF);
		random_phase(250, 15, 55);
		load_start_thread(ID_BITS'($urandom));
		random_phase(300, 60, 5);
		load_start_thread(8'h00);
		random_phase(300, 40, 25);
		load_start_thread(ID_BITS'($urandom));
		random_phase(200, 10, 60);
		load_start_thread(ID_BITS'($urandom));
		random_phase(175, 40, 30);
	endtask

	// receiver: steady, random and periodic stall stretches
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 2));
			rx_left = $urandom_range(20, 120);
		end
		rx_left--;
		rx_step++;
		case (rx_mode)
			RX_STEADY:   out_ready <= 1'b1;
			RX_RANDOM:   out_ready <= ($urandom_range(0, 3) != 0);
			default:     out_ready <= ((rx_step % 5) < 2);
		endcase
	end

	// check each result against the oldest outcome
	always @(posedge clk) begin
		outcome_t o;
		if (arst_n && out_valid && out_ready) begin
			if (pending_outcomes.size() == 0) begin
				$display("%0t: result with no request pending: running %0d count %0d",
					$time, running_thread, queue_count);
				error_count++;
			end else begin
				o = pending_outcomes.pop_front();
				if (running_thread !== o.running)
					report_mismatch("running_thread", o.running, running_thread);
				if (switched !== o.switched)
					report_mismatch("switched", ID_BITS'(o.switched), ID_BITS'(switched));
				if (status !== o.status)
					report_mismatch("status", ID_BITS'(o.status), ID_BITS'(status));
				if (queue_count !== o.count)
					report_mismatch("queue_count", ID_BITS'(o.count),
						ID_BITS'(queue_count));
			end
		end
	end

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		action = ACT_SCHEDULE;
		thread_id = '0;
		out_ready = 1'b0;
		running_id = '0;
		error_count = 0;
		idle_cycles = 0;
		burst_left = 0;
		rx_left = 0;
		rx_step = 0;
		rx_mode = RX_STEADY;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		test_empty_queue();
		test_rotation_and_removal();
		test_queue_full();
		test_random_mix();

		drain_requests();
		repeat (40) @(negedge clk);
		if (error_count == 0 && pending_outcomes.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ----- files.f -----
design/rrq_pkg.sv
design/rrq_mem.sv
design/rrq_ctrl.sv
design/round_robin_ready_queue.sv
sim/round_robin_ready_queue_tb.sv
